// File: src/lzib_pkg.sv
// Shared types, phase codes and tables for the indexed bitmap LZ decoder.
package lzib_pkg;

  localparam int WINDOW_BYTES_DEF = 1024;

  // Parser phases
  localparam logic [2:0] PH_TOP   = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_SUB   = 3'd2;
  localparam logic [2:0] PH_ARG1  = 3'd3;
  localparam logic [2:0] PH_ARG2  = 3'd4;
  localparam logic [2:0] PH_EXTRA = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] pending;
    logic [6:0] lits;
    logic [5:0] subs;
    logic [7:0] gath;
  } parse_st_t;

  // One step's byte job: byte 0 and byte 1 may be literals or carry a delta,
  // every later byte is a plain copy at distance dist1.
  typedef struct packed {
    logic [7:0] len;
    logic [9:0] dist0;
    logic [9:0] dist1;
    logic [7:0] delta0;
    logic [7:0] delta1;
    logic       lit0_en;
    logic [7:0] lit0;
    logic       lit1_en;
    logic [7:0] lit1;
    logic       bad;
    logic       stop;
  } job_t;

  // Copy length of the short back-reference forms; zero marks an undefined form.
  function automatic logic [3:0] copy_len(input logic [1:0] grp, input logic [1:0] mode);
    logic [3:0] r;
    begin
      r = 4'd0;
      unique case ({grp, mode})
        4'h0: r = 4'd5;  4'h1: r = 4'd3;  4'h2: r = 4'd4;  4'h3: r = 4'd5;
        4'h4: r = 4'd8;  4'h5: r = 4'd6;  4'h6: r = 4'd7;  4'h7: r = 4'd8;
        4'h8: r = 4'd0;  4'h9: r = 4'd9;  4'ha: r = 4'd10; 4'hb: r = 4'd11;
        4'hc: r = 4'd0;  4'hd: r = 4'd12; 4'he: r = 4'd13; 4'hf: r = 4'd0;
        default: r = 4'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/lzib_dec.sv
// Command parser: turns one compressed byte and the parser state into a byte job.
module lzib_dec (
  input  logic [7:0]        v,
  input  lzib_pkg::parse_st_t st,
  output lzib_pkg::parse_st_t nst,
  output lzib_pkg::job_t    job
);
  import lzib_pkg::*;

  logic [3:0] hi, lo, clen;
  logic [7:0] code;
  logic       sdone;
  logic [6:0] lnum;
  logic [5:0] nsubs;
  logic [1:0] grp;

  always_comb begin
    nst   = st;
    job   = '0;
    sdone = 1'b0;
    code  = (st.phase == PH_SUB) ? v : st.pending;
    hi    = code[7:4];
    lo    = code[3:0];
    grp   = {hi[2], hi[0]};
    clen  = copy_len(grp, lo[3:2]);
    lnum  = 7'(st.gath[7:2]) + 7'd3;
    nsubs = 6'd0;
    job.dist0 = 10'd2;
    job.dist1 = 10'd2;
    unique case (st.phase)
      PH_LIT: begin
        job.len = 8'd1; job.lit0_en = 1'b1; job.lit0 = v;
        if (st.lits > 7'd0) nst.lits = st.lits - 7'd1;
        if (nst.lits == 7'd0) nst.phase = PH_TOP;
      end
      PH_SUB: begin
        sdone = 1'b1;
        job.len = 8'd2;
        unique case (hi)
          4'h0: begin
            job.dist0 = 10'({lo, 1'b0}); job.dist1 = 10'({lo, 1'b0});
          end
          4'h2: job.delta1 = 8'(lo);
          4'h3: job.delta1 = 8'd0 - 8'(lo);
          4'h8: job.delta0 = 8'(lo);
          4'hc: job.delta0 = 8'd0 - 8'(lo);
          4'h1, 4'h4: begin
            if (lo != 4'd0) begin
              if (hi == 4'h1) job.dist1 = 10'(lo);
              else job.dist0 = 10'(lo);
            end else begin
              sdone = 1'b0; job.len = 8'd0;
              nst.pending = code; nst.phase = PH_ARG1;
            end
          end
          default: begin
            sdone = 1'b0; job.len = 8'd0;
            nst.pending = code; nst.phase = PH_ARG1;
          end
        endcase
      end
      PH_ARG1: begin
        sdone = 1'b1;
        job.len = 8'd2;
        unique case (hi)
          4'h1: begin job.lit1_en = 1'b1; job.lit1 = v; end
          4'h4: begin job.lit0_en = 1'b1; job.lit0 = v; end
          4'h5: begin
            if (lo == 4'd0) begin
              sdone = 1'b0; job.len = 8'd0;
              nst.gath = v; nst.phase = PH_ARG2;
            end else if (!lo[3]) begin
              job.dist0 = 10'(lo); job.lit1_en = 1'b1; job.lit1 = v;
            end else begin
              job.lit0_en = 1'b1; job.lit0 = v; job.dist1 = 10'(lo[2:0]);
            end
          end
          4'h6: begin job.lit0_en = 1'b1; job.lit0 = v; job.delta1 = 8'(lo); end
          4'h7: begin job.lit0_en = 1'b1; job.lit0 = v; job.delta1 = 8'd0 - 8'(lo); end
          4'h9: begin job.delta0 = 8'(lo); job.lit1_en = 1'b1; job.lit1 = v; end
          4'hd: begin job.delta0 = 8'd0 - 8'(lo); job.lit1_en = 1'b1; job.lit1 = v; end
          4'ha, 4'hb, 4'he, 4'hf: begin
            if (lo == 4'd0) begin
              job.delta0 = (!hi[2]) ? 8'(v[7:4]) : 8'd0 - 8'(v[7:4]);
              job.delta1 = (!hi[0]) ? 8'(v[3:0]) : 8'd0 - 8'(v[3:0]);
            end else if (hi == 4'hf && lo[3:2] == 2'b11) begin
              sdone = 1'b0; job.len = 8'd0;
              nst.gath = v; nst.phase = PH_ARG2;
            end else if (clen == 4'd0) begin
              job.lit0_en = 1'b1; job.lit1_en = 1'b1; job.bad = 1'b1;
            end else begin
              job.len = 8'(clen);
              job.dist0 = {lo[1:0], v}; job.dist1 = {lo[1:0], v};
              if (clen[0]) begin sdone = 1'b0; nst.phase = PH_EXTRA; end
            end
          end
          default: job.len = 8'd0;
        endcase
      end
      PH_ARG2: begin
        sdone = 1'b1;
        if (hi == 4'h5) begin
          job.len = 8'd2; job.lit0_en = 1'b1; job.lit0 = st.gath;
          job.lit1_en = 1'b1; job.lit1 = v;
        end else begin
          job.len = 8'(lnum);
          job.dist0 = {st.gath[1:0], v}; job.dist1 = {st.gath[1:0], v};
          if (lnum[0]) begin sdone = 1'b0; nst.phase = PH_EXTRA; end
        end
      end
      PH_EXTRA: begin
        sdone = 1'b1; job.len = 8'd1; job.lit0_en = 1'b1; job.lit0 = v;
      end
      default: begin
        nst.phase = PH_TOP;
        if (v == 8'd0) begin
          job.stop = 1'b1;
        end else begin
          unique case (v[7:6])
            2'b00: begin nst.lits = {v[5:0], 1'b0}; nst.phase = PH_LIT; end
            2'b01: job.len = 8'({v[5:0], 1'b0});
            2'b10: begin
              job.len = {v[5:0], 2'b00}; job.dist0 = 10'd4; job.dist1 = 10'd4;
            end
            default: begin
              if (v[5:0] != 6'd0) begin nst.subs = v[5:0]; nst.phase = PH_SUB; end
            end
          endcase
        end
      end
    endcase
    if (sdone) begin
      nsubs = (st.subs > 6'd0) ? st.subs - 6'd1 : st.subs;
      nst.subs  = nsubs;
      nst.phase = (nsubs == 6'd0) ? PH_TOP : PH_SUB;
    end
  end

endmodule

// File: src/lz_indexed_bitmap_decoder_core.sv
// Top level of the indexed bitmap LZ decoder: history memory, byte engine and packer.
// Each accepted item (one compressed byte) is parsed in the idle state; if it decodes
// any bytes, the first history read is started, then every byte is read from, modified
// and written back to the single history RAM in turn; an item that only reports status
// passes through a status state instead. The byte engine stalls while a result waits
// and the receiver is not ready. No new item is taken until the last one is through.
// Results carry up to four bytes, earliest in the low byte. After reset the history is
// cleared, one entry per cycle, and no item is accepted until that is done.
module lz_indexed_bitmap_decoder_core #(
  parameter int WINDOW_BYTES = lzib_pkg::WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,   // total_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // stream_byte
  input  logic [0:0]  in_tuser,      // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // data_word[31:0], byte_count[34:32], zero pad
  output logic        out_tlast,     // last_of_run
  output logic [2:0]  out_tuser      // image_done, overflow, bad_code
);
  import lzib_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [AW:0]   WSIZE = (AW + 1)'(WINDOW_BYTES);
  localparam logic [AW-1:0] WLAST = AW'(WINDOW_BYTES - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD0  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt, wp_r, wp_nxt;
  logic [23:0]   total_r, total_nxt, prod_r, prod_nxt;
  logic          fin_r, fin_nxt;
  parse_st_t     st_r, st_nxt;
  job_t          job_r, job_nxt;
  logic [7:0]    k_r, k_nxt, elen_r, elen_nxt;
  logic          fdone_r, fdone_nxt, fdrop_r, fdrop_nxt, fbad_r, fbad_nxt;
  logic [23:0]   pack_r, pack_nxt;
  logic [1:0]    pcnt_r, pcnt_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_d_r, fwd_d_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   ow_r, ow_nxt;
  logic [2:0]    oc_r, oc_nxt;
  logic          ol_r, ol_nxt;
  logic [2:0]    ouser_r, ouser_nxt;

  logic [7:0]    mem [WINDOW_BYTES];
  logic [7:0]    rd_q_r;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  parse_st_t st_eff, dec_nst;
  job_t      dec_job;
  logic [23:0] prod_eff, room, pfin;
  logic        fin_eff, accept, go, drop, fin_new, evt;
  logic [7:0]  elen_c, src, bval;
  logic [AW-1:0] wp_inc;
  logic [AW:0]   diff;
  logic [AW-1:0] base;
  logic [9:0]    rdist;
  logic [31:0]   wordv;

  lzib_dec u_dec (
    .v   (in_tdata),
    .st  (st_eff),
    .nst (dec_nst),
    .job (dec_job)
  );

  assign accept    = (state_r == S_IDLE) && in_tvalid;
  assign in_tready = (state_r == S_IDLE);
  assign go        = !ov_r || out_tready;
  assign wp_inc    = (wp_r == WLAST) ? '0 : wp_r + 1'b1;

  always_comb begin
    st_eff   = in_tuser[0] ? '0 : st_r;
    prod_eff = in_tuser[0] ? 24'd0 : prod_r;
    fin_eff  = in_tuser[0] ? 1'b0 : fin_r;
    room     = (prod_eff < total_r) ? total_r - prod_eff : 24'd0;
    drop     = 24'(dec_job.len) > room;
    elen_c   = drop ? room[7:0] : dec_job.len;
    pfin     = prod_eff + 24'(elen_c);
    fin_new  = dec_job.stop || ((dec_nst.phase == PH_TOP) && (pfin >= total_r));
    evt      = fin_new || drop || dec_job.bad;
    // History address = position minus distance, modulo the window size.
    base  = (state_r == S_RD0) ? wp_r : wp_inc;
    rdist = (state_r == S_RD0) ? job_r.dist0 : job_r.dist1;
    diff  = {1'b0, base} - (AW + 1)'(rdist);
    if (diff[AW]) diff = diff + WSIZE;
    ra    = diff[AW-1:0];
    src   = fwd_r ? fwd_d_r : rd_q_r;
    if (k_r == 8'd0) bval = job_r.lit0_en ? job_r.lit0 : src + job_r.delta0;
    else if (k_r == 8'd1) bval = job_r.lit1_en ? job_r.lit1 : src + job_r.delta1;
    else bval = src;
    wordv = {8'd0, pack_r} | (32'(bval) << {pcnt_r, 3'b000});
  end

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; wp_nxt = wp_r;
    total_nxt = cfg_wr_en ? cfg_wr_data : total_r;
    prod_nxt = prod_r; fin_nxt = fin_r; st_nxt = st_r; job_nxt = job_r;
    k_nxt = k_r; elen_nxt = elen_r;
    fdone_nxt = fdone_r; fdrop_nxt = fdrop_r; fbad_nxt = fbad_r;
    pack_nxt = pack_r; pcnt_nxt = pcnt_r; fwd_nxt = fwd_r; fwd_d_nxt = fwd_d_r;
    ov_nxt = out_tready ? 1'b0 : ov_r;
    ow_nxt = ow_r; oc_nxt = oc_r; ol_nxt = ol_r; ouser_nxt = ouser_r;
    we = 1'b0; re = 1'b0; wa = wp_r; wd = bval;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1; wa = clr_r; wd = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == WLAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          st_nxt = st_eff; prod_nxt = prod_eff; fin_nxt = fin_eff;
          if (in_tuser[0]) wp_nxt = '0;
          pack_nxt = '0; pcnt_nxt = '0; k_nxt = '0;
          fdrop_nxt = 1'b0; fbad_nxt = 1'b0; fdone_nxt = 1'b1;
          if (fin_eff) begin
            state_nxt = S_IDLE;
          end else if (st_eff.phase == PH_TOP && prod_eff >= total_r) begin
            fin_nxt = 1'b1; elen_nxt = '0; state_nxt = S_STAT;
          end else begin
            st_nxt = dec_nst; job_nxt = dec_job; elen_nxt = elen_c;
            prod_nxt = pfin; fin_nxt = fin_new;
            fdone_nxt = fin_new; fdrop_nxt = drop; fbad_nxt = dec_job.bad;
            if (dec_job.len != 8'd0) state_nxt = S_RD0;
            else state_nxt = evt ? S_STAT : S_IDLE;
          end
        end
      end
      S_RD0: begin
        re = 1'b1; fwd_nxt = 1'b0; state_nxt = S_RUN;
      end
      S_RUN: begin
        if (go) begin
          we = 1'b1; wa = wp_r; wd = bval; wp_nxt = wp_inc;
          re = 1'b1;
          // A read of the entry being written this cycle takes the new byte.
          fwd_nxt = (ra == wp_r); fwd_d_nxt = bval;
          k_nxt = k_r + 8'd1;
          if (k_r < elen_r) begin
            if (pcnt_r == 2'd3 || k_r == elen_r - 8'd1) begin
              ov_nxt = 1'b1; ow_nxt = wordv; oc_nxt = 3'(pcnt_r) + 3'd1;
              ol_nxt = (k_r == elen_r - 8'd1);
              ouser_nxt = {fbad_r, fdrop_r, fdone_r};
              pack_nxt = '0; pcnt_nxt = '0;
            end else begin
              pack_nxt = wordv[23:0]; pcnt_nxt = pcnt_r + 2'd1;
            end
          end
          if (k_r == job_r.len - 8'd1)
            state_nxt = (elen_r == 8'd0) ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (go) begin
          ov_nxt = 1'b1; ow_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
          ouser_nxt = {fbad_r, fdrop_r, fdone_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; wp_r <= '0; total_r <= '0; prod_r <= '0;
      fin_r <= 1'b0; st_r <= '0; k_r <= '0; elen_r <= '0; ov_r <= 1'b0;
      pcnt_r <= '0; fwd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; wp_r <= wp_nxt; total_r <= total_nxt;
      prod_r <= prod_nxt; fin_r <= fin_nxt; st_r <= st_nxt; k_r <= k_nxt;
      elen_r <= elen_nxt; ov_r <= ov_nxt; pcnt_r <= pcnt_nxt; fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt; fdone_r <= fdone_nxt; fdrop_r <= fdrop_nxt; fbad_r <= fbad_nxt;
    pack_r <= pack_nxt; fwd_d_r <= fwd_d_nxt; ow_r <= ow_nxt; oc_r <= oc_nxt;
    ol_r <= ol_nxt; ouser_r <= ouser_nxt;
  end

  // The flags travel with the result word, since the next item may be parsed while
  // a result still waits.
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, oc_r, ow_r};
  assign out_tlast  = ol_r;
  assign out_tuser  = ouser_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34:32] == 3'd0) |-> out_tlast)
    else $error("status-only result without last marker");
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[34:32] == 3'd4))
    else $error("partial word before the last result of an item");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we)
    else $error("history written while idle");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_tready && !out_tvalid))
    else $error("traffic during history clearing");

endmodule

// File: tb/sv/tb_lz_indexed_bitmap_decoder_core.sv
// Self-checking testbench for the indexed bitmap LZ decoder core.
`timescale 1ns / 100ps

module tb_lz_indexed_bitmap_decoder_core;
  import lzib_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
    logic        done;
    logic        ovf;
    logic        bad;
  } pixels_t;

  typedef struct {
    int          total;    // -1 leaves the register alone
    logic [7:0]  code;
    logic        fs;
    bit          known;
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        done;
    logic        bad;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;       // stream_byte
  logic [0:0]  in_tuser = '0;       // frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // data_word, byte_count, zero pad
  logic        out_tlast;           // last_of_run
  logic [2:0]  out_tuser;           // image_done, overflow, bad_code

  lz_indexed_bitmap_decoder_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  // Decoder shadow state.
  logic [7:0]  hist [1024];
  int unsigned wpos, made, total_cfg;
  logic [2:0]  phase;
  logic [7:0]  pending;
  int unsigned lits, subs;
  logic [15:0] gath;
  bit          fin;
  logic [7:0]  run_bytes [$];
  bit          run_drop, run_bad;
  pixels_t     pixels_q [$];

  int unsigned n_items, n_results, n_errors, n_ovf, n_bad, n_done;
  int          stall_pct, idle_pct, hold_left;

  const int short_len [16] = '{5, 3, 4, 5, 8, 6, 7, 8, 0, 9, 10, 11, 0, 12, 13, 0};

  function automatic logic [7:0] hist_at(int unsigned d);
    return hist[(wpos + 1024 - (d % 1024)) % 1024];
  endfunction

  function automatic void emit(int unsigned b);
    hist[wpos] = b[7:0];
    wpos = (wpos + 1) % 1024;
    if (made < total_cfg) begin
      run_bytes.push_back(b[7:0]);
      made++;
    end else
      run_drop = 1'b1;
  endfunction

  function automatic void copy_back(int unsigned d, int unsigned n);
    for (int k = 0; k < n; k++) emit(hist_at(d));
  endfunction

  function automatic void sub_finish();
    if (subs > 0) subs--;
    phase = (subs == 0) ? PH_TOP : PH_SUB;
  endfunction

  function automatic void sub_first(logic [7:0] c);
    logic [3:0] lo;
    int unsigned a, b;
    lo = c[3:0];
    case (c[7:4])
      4'h0: begin emit(hist_at(2 * lo)); emit(hist_at(2 * lo)); end
      4'h2: begin a = hist_at(2); b = hist_at(1) + lo; emit(a); emit(b); end
      4'h3: begin a = hist_at(2); b = hist_at(1) - lo; emit(a); emit(b); end
      4'h8: begin a = hist_at(2) + lo; b = hist_at(1); emit(a); emit(b); end
      4'hc: begin a = hist_at(2) - lo; b = hist_at(1); emit(a); emit(b); end
      4'h1: begin
        if (lo == 0) begin pending = c; phase = PH_ARG1; return; end
        emit(hist_at(2)); emit(hist_at(lo));
      end
      4'h4: begin
        if (lo == 0) begin pending = c; phase = PH_ARG1; return; end
        a = hist_at(lo); b = hist_at(1); emit(a); emit(b);
      end
      default: begin pending = c; phase = PH_ARG1; return; end
    endcase
    sub_finish();
  endfunction

  function automatic void sub_second(logic [7:0] c, logic [7:0] v);
    logic [3:0] hi, lo;
    int unsigned a, b, n, g;
    hi = c[7:4];
    lo = c[3:0];
    case (hi)
      4'h1: begin emit(hist_at(2)); emit(v); end
      4'h4: begin b = hist_at(1); emit(v); emit(b); end
      4'h5: begin
        if (lo == 0) begin gath = {8'h00, v}; phase = PH_ARG2; return; end
        if (lo < 8) begin emit(hist_at(lo)); emit(v); end
        else begin emit(v); emit(hist_at(lo & 4'h7)); end
      end
      4'h6: begin b = hist_at(1) + lo; emit(v); emit(b); end
      4'h7: begin b = hist_at(1) - lo; emit(v); emit(b); end
      4'h9: begin emit(hist_at(2) + lo); emit(v); end
      4'hd: begin emit(hist_at(2) - lo); emit(v); end
      4'ha, 4'hb, 4'he, 4'hf: begin
        if (lo == 0) begin
          a = (hi == 4'ha || hi == 4'hb) ? hist_at(2) + v[7:4] : hist_at(2) - v[7:4];
          b = (hi == 4'ha || hi == 4'he) ? hist_at(1) + v[3:0] : hist_at(1) - v[3:0];
          emit(a); emit(b);
        end else if (hi == 4'hf && lo >= 4'hc) begin
          gath = {v, 8'h00};
          phase = PH_ARG2;
          return;
        end else begin
          g = (hi == 4'ha) ? 0 : (hi == 4'hb) ? 1 : (hi == 4'he) ? 2 : 3;
          n = short_len[g * 4 + lo[3:2]];
          if (n == 0) begin
            emit(0); emit(0);
            run_bad = 1'b1;
          end else begin
            copy_back({lo[1:0], v}, n);
            if (n % 2 == 1) begin phase = PH_EXTRA; return; end
          end
        end
      end
      default: ;
    endcase
    sub_finish();
  endfunction

  function automatic void sub_third(logic [7:0] c, logic [7:0] v);
    logic [15:0] val;
    int unsigned n;
    if (c[7:4] == 4'h5) begin
      emit(gath[7:0]);
      emit(v);
    end else begin
      val = {gath[15:8], v};
      n = val[15:10] + 3;
      copy_back(val[9:0], n);
      if (n % 2 == 1) begin phase = PH_EXTRA; return; end
    end
    sub_finish();
  endfunction

  function automatic void top_code(logic [7:0] b);
    logic [7:0] q0, q1, q2, q3;
    int unsigned n;
    n = b[5:0];
    if (b == 8'h00) begin fin = 1'b1; return; end
    case (b[7:6])
      2'b00: begin lits = 2 * n; phase = PH_LIT; end
      2'b01: begin
        q0 = hist_at(2); q1 = hist_at(1);
        for (int k = 0; k < n; k++) begin emit(q0); emit(q1); end
      end
      2'b10: begin
        q0 = hist_at(4); q1 = hist_at(3); q2 = hist_at(2); q3 = hist_at(1);
        for (int k = 0; k < n; k++) begin emit(q0); emit(q1); emit(q2); emit(q3); end
      end
      default: if (n != 0) begin subs = n; phase = PH_SUB; end
    endcase
  endfunction

  function automatic void new_image();
    wpos = 0; made = 0; phase = PH_TOP; pending = '0;
    lits = 0; subs = 0; gath = '0; fin = 1'b0;
  endfunction

  // Works out the packed results that one compressed byte causes.
  function automatic void decode_byte(logic [7:0] v, logic fs);
    pixels_t r;
    int unsigned nres, len;
    run_bytes.delete();
    run_drop = 1'b0;
    run_bad = 1'b0;
    if (fs) new_image();
    if (fin) return;
    if (phase == PH_TOP && made >= total_cfg) fin = 1'b1;
    else begin
      case (phase)
        PH_LIT: begin
          emit(v);
          if (lits > 0) lits--;
          if (lits == 0) phase = PH_TOP;
        end
        PH_SUB:   sub_first(v);
        PH_ARG1:  sub_second(pending, v);
        PH_ARG2:  sub_third(pending, v);
        PH_EXTRA: begin emit(v); sub_finish(); end
        default:  begin phase = PH_TOP; top_code(v); end
      endcase
      if (phase == PH_TOP && made >= total_cfg) fin = 1'b1;
    end
    len = run_bytes.size();
    if (len == 0 && !(fin || run_drop || run_bad)) return;
    nres = (len + 3) / 4;
    if (nres == 0) nres = 1;
    for (int k = 0; k < nres; k++) begin
      r.word = '0;
      r.cnt = '0;
      for (int j = 0; j < 4; j++)
        if (k * 4 + j < len) begin
          r.word[8*j +: 8] = run_bytes[k * 4 + j];
          r.cnt++;
        end
      r.last = (k + 1 == nres);
      r.done = fin;
      r.ovf = run_drop;
      r.bad = run_bad;
      pixels_q.push_back(r);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Input items are predicted and results checked on the same sampling edge.
  always @(posedge clk) begin
    pixels_t e;
    if (out_tvalid && out_tready) begin
      n_results++;
      if (pixels_q.size() == 0)
        report("result with nothing expected, data", out_tdata[31:0], 0);
      else begin
        e = pixels_q.pop_front();
        if (out_tdata[31:0] !== e.word) report("data_word", out_tdata[31:0], e.word);
        if (out_tdata[34:32] !== e.cnt) report("byte_count", out_tdata[34:32], e.cnt);
        if (out_tlast !== e.last) report("last_of_run", out_tlast, e.last);
        if (out_tuser[0] !== e.done) report("image_done", out_tuser[0], e.done);
        if (out_tuser[1] !== e.ovf) report("overflow", out_tuser[1], e.ovf);
        if (out_tuser[2] !== e.bad) report("bad_code", out_tuser[2], e.bad);
        n_ovf += e.ovf;
        n_bad += e.bad;
        n_done += e.done & e.last;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, in_tuser[0]);
      n_items++;
    end
  end

  // Receiver: random stalls, plus a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else
      out_tready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic [7:0] v, logic fs);
    int unsigned target;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = v;
    in_tuser = fs;
    target = n_items + 1;
    do @(negedge clk); while (n_items != target);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pixels_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_total(int unsigned value);
    drain();
    // An item that reports nothing may still be in the byte engine.
    repeat (80) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value[23:0];
    total_cfg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  // One subcommand with exactly the operand bytes its form consumes.
  task automatic send_sub();
    logic [7:0] c, a1, a2;
    int unsigned n;
    c = rnd8();
    send(c, 1'b0);
    case (c[7:4])
      4'h0, 4'h2, 4'h3, 4'h8, 4'hc: ;
      4'h1, 4'h4: if (c[3:0] == 0) send(rnd8(), 1'b0);
      4'h5: begin
        send(rnd8(), 1'b0);
        if (c[3:0] == 0) send(rnd8(), 1'b0);
      end
      4'h6, 4'h7, 4'h9, 4'hd: send(rnd8(), 1'b0);
      default: begin
        a1 = rnd8();
        send(a1, 1'b0);
        if (c[3:0] != 0) begin
          if (c[7:4] == 4'hf && c[3:0] >= 4'hc) begin
            a2 = rnd8();
            send(a2, 1'b0);
            n = a1[7:2] + 3;
          end else
            n = short_len[(c[7:4] == 4'ha ? 0 : c[7:4] == 4'hb ? 1 : c[7:4] == 4'he ? 2 : 3) * 4
                          + c[3:2]];
          if (n % 2 == 1) send(rnd8(), 1'b0);
        end
      end
    endcase
  endtask

  task automatic send_image(int unsigned cmds);
    int unsigned n, pick;
    send(8'($urandom_range(1, 255)) & 8'hbf | 8'h01, 1'b1);
    repeat (cmds) begin
      pick = $urandom_range(99);
      n = ($urandom_range(19) == 0) ? 63 : $urandom_range(1, 5);
      if (pick < 30) begin
        send({2'b00, 6'(n > 8 ? 20 : n)}, 1'b0);
        repeat (2 * (n > 8 ? 20 : n)) send(rnd8(), 1'b0);
      end else if (pick < 45) send({2'b01, 6'(n)}, 1'b0);
      else if (pick < 55) send({2'b10, 6'(n)}, 1'b0);
      else if (pick < 90) begin
        n = $urandom_range(1, 4);
        send({2'b11, 6'(n)}, 1'b0);
        repeat (n) send_sub();
      end else
        repeat ($urandom_range(1, 4)) send(rnd8(), 1'b0);   // raw noise
    end
    if ($urandom_range(3) == 0) send(8'h00, 1'b0);
  endtask

  dir_row_t dir_tab [] = '{
    '{-1, 8'h55, 1, 1, 32'h0, 3'd0, 1, 0},
    '{-1, 8'haa, 0, 0, 32'h0, 3'd0, 0, 0},
    '{64, 8'h02, 1, 0, 32'h0, 3'd0, 0, 0},
    '{-1, 8'h11, 0, 1, 32'h11, 3'd1, 0, 0},
    '{-1, 8'h22, 0, 1, 32'h22, 3'd1, 0, 0},
    '{-1, 8'h33, 0, 1, 32'h33, 3'd1, 0, 0},
    '{-1, 8'h44, 0, 1, 32'h44, 3'd1, 0, 0},
    '{-1, 8'h41, 0, 1, 32'h4433, 3'd2, 0, 0},
    '{-1, 8'h81, 0, 1, 32'h44334433, 3'd4, 0, 0},
    '{-1, 8'hc6, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h03, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h25, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hc1, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h12, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h10, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hff, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h50, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hab, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hcd, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hc4, 0, 0, 0, 0, 0, 0},
    '{-1, 8'he1, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h05, 0, 1, 32'h0, 3'd2, 0, 1},
    '{-1, 8'ha4, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h02, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h7e, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hf0, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h5a, 0, 0, 0, 0, 0, 0},
    '{-1, 8'hfc, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h00, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h05, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h99, 0, 0, 0, 0, 0, 0},
    '{-1, 8'h00, 0, 1, 32'h0, 3'd0, 1, 0},
    '{3, 8'h42, 1, 0, 0, 0, 0, 0}
  };

  initial begin
    for (int i = 0; i < 1024; i++) hist[i] = '0;
    new_image();
    total_cfg = 0;
    stall_pct = 0;
    idle_pct = 0;
    hold_left = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].total >= 0) set_total(dir_tab[i].total);
      send(dir_tab[i].code, dir_tab[i].fs);
      if (dir_tab[i].known) begin
        if (pixels_q.size() == 0)
          report("directed item gave no result, code", dir_tab[i].code, 0);
        else begin
          if (pixels_q[$].word !== dir_tab[i].word)
            report("directed data_word", pixels_q[$].word, dir_tab[i].word);
          if (pixels_q[$].cnt !== dir_tab[i].cnt)
            report("directed byte_count", pixels_q[$].cnt, dir_tab[i].cnt);
          if (pixels_q[$].done !== dir_tab[i].done)
            report("directed image_done", pixels_q[$].done, dir_tab[i].done);
          if (pixels_q[$].bad !== dir_tab[i].bad)
            report("directed bad_code", pixels_q[$].bad, dir_tab[i].bad);
        end
      end
    end

    set_total(300);
    while (n_items < 110) send_image($urandom_range(4, 12));
    set_total(24'hffffff);
    idle_pct = 60;
    while (n_items < 190) send_image($urandom_range(4, 12));
    set_total(40);
    idle_pct = 0;
    stall_pct = 60;
    while (n_items < 270) send_image($urandom_range(3, 10));

    // Long receiver hold-off while large repeats keep arriving.
    set_total(2000);
    stall_pct = 0;
    hold_left = 400;
    send(8'h04, 1'b1);
    repeat (8) send(rnd8(), 1'b0);
    repeat (12) send(8'hbf, 1'b0);
    drain();
    send(8'h7f, 1'b0);

    set_total(1000);
    idle_pct = 32;
    stall_pct = 32;
    while (n_items < 385) send_image($urandom_range(4, 12));
    set_total(0);
    idle_pct = 0;
    stall_pct = 0;
    while (n_items < 410) send_image($urandom_range(2, 6));

    drain();
    repeat (100) @(negedge clk);
    $display("Covered %0d compressed bytes and %0d results: %0d finished images,",
             n_items, n_results, n_done);
    $display("%0d results with dropped bytes and %0d with undefined subcommands.", n_ovf, n_bad);
    if (n_errors == 0 && pixels_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results still expected", pixels_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
